// File: design/rdif_pkg.sv
// Shared types and constants for the resource descriptor interrupt finder.
// No dependencies; used by the parser, the top level and the checker.
`default_nettype none

package rdif_pkg;

  // Descriptor tag fields
  localparam logic [7:0] TAG_LARGE_BIT = 8'h80;
  localparam logic [7:0] TAG_EXT_IRQ   = 8'h89;
  localparam logic [3:0] NAME_END      = 4'hF;
  localparam logic [3:0] NAME_IRQ      = 4'h4;

  // Result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_LARGE = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_IRQ   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        level_triggered;
    logic        pol_low;
    logic [31:0] gsi;
    logic        found;
  } result_t;

endpackage

`default_nettype wire

// File: design/rdif_parser.sv
// Byte-serial descriptor parser: holds the parse state and decodes one byte per step.
// Depends on rdif_pkg.
`default_nettype none

module rdif_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire rdif_pkg::step_t   step,
  output rdif_pkg::result_t      result
);

  rdif_pkg::phase_t phase_r, phase_nxt;
  logic [16:0] offset_r, offset_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [31:0] gsi_r, gsi_nxt;
  logic [7:0]  mask_lo_r, mask_lo_nxt;
  logic        decided_r, decided_nxt;
  logic [1:0]  hstat_r, hstat_nxt;
  logic [31:0] hgsi_r, hgsi_nxt;
  logic        halow_r, halow_nxt;
  logic        hlvl_r, hlvl_nxt;

  logic [7:0]  b;
  logic [15:0] len_eff;
  logic        ext;
  logic        run_tag;
  logic [1:0]  lane;
  logic [31:0] gsi_acc;
  logic [15:0] mask_full;
  logic [3:0]  low_bit;

  assign b = step.data_byte;

  always_comb begin
    low_bit = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_full[i]) begin
        low_bit = 4'(i);
      end
    end
  end

  assign mask_full = {b, mask_lo_r};
  assign lane      = offset_r[1:0] - 2'd1;
  assign gsi_acc   = gsi_r | ({24'd0, b} << {lane, 3'b000});

  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    tag_nxt     = tag_r;
    len_nxt     = len_r;
    flags_nxt   = flags_r;
    count_nxt   = count_r;
    gsi_nxt     = gsi_r;
    mask_lo_nxt = mask_lo_r;
    decided_nxt = decided_r;
    hstat_nxt   = hstat_r;
    hgsi_nxt    = hgsi_r;
    halow_nxt   = halow_r;
    hlvl_nxt    = hlvl_r;
    run_tag     = 1'b0;
    len_eff     = len_r;
    ext         = 1'b0;

    if (!decided_r) begin
      unique case (phase_r)
        rdif_pkg::PH_TAG: begin
          run_tag = 1'b1;
        end
        rdif_pkg::PH_LARGE: begin
          if (offset_r == 17'd1) begin
            len_eff = {8'd0, b};
          end else if (offset_r == 17'd2) begin
            len_eff = {b, len_r[7:0]};
          end
          len_nxt = len_eff;
          ext = (tag_r == rdif_pkg::TAG_EXT_IRQ) && (len_eff >= 16'd6);
          if (ext && offset_r == 17'd8 && count_r != 8'd0) begin
            gsi_nxt     = gsi_acc;
            decided_nxt = 1'b1;
            hstat_nxt   = rdif_pkg::ST_FOUND;
            hgsi_nxt    = gsi_acc;
            halow_nxt   = flags_r[2];
            hlvl_nxt    = ~flags_r[1];
          end else begin
            if (ext && offset_r == 17'd3) begin
              flags_nxt = b;
            end else if (ext && offset_r == 17'd4) begin
              count_nxt = b;
            end else if (ext && offset_r >= 17'd5 && offset_r <= 17'd8) begin
              gsi_nxt = gsi_acc;
            end
            // End of descriptor: back to a tag, drop the partial interrupt fields
            if (offset_r >= 17'd2 && offset_r == {1'b0, len_eff} + 17'd2) begin
              phase_nxt  = rdif_pkg::PH_TAG;
              offset_nxt = 17'd0;
              gsi_nxt    = 32'd0;
              flags_nxt  = 8'd0;
              count_nxt  = 8'd0;
            end else begin
              offset_nxt = offset_r + 17'd1;
            end
          end
        end
        rdif_pkg::PH_SKIP: begin
          len_nxt = len_r - 16'd1;
          if (len_r == 16'd1) begin
            phase_nxt = rdif_pkg::PH_TAG;
          end
        end
        rdif_pkg::PH_IRQ: begin
          if (offset_r == 17'd1) begin
            // Zero-length IRQ cut short: reparse this byte as a tag
            if (step.last_byte && len_r == 16'd0) begin
              run_tag = 1'b1;
            end else begin
              mask_lo_nxt = b;
              offset_nxt  = 17'd2;
            end
          end else if (offset_r == 17'd2) begin
            if (mask_full == 16'd0) begin
              decided_nxt = 1'b1;
              hstat_nxt   = rdif_pkg::ST_EMPTY;
              hgsi_nxt    = 32'd0;
              halow_nxt   = 1'b0;
              hlvl_nxt    = 1'b0;
            end else begin
              gsi_nxt = {28'd0, low_bit};
              if (len_r < 16'd3 || step.last_byte) begin
                decided_nxt = 1'b1;
                hstat_nxt   = rdif_pkg::ST_FOUND;
                hgsi_nxt    = {28'd0, low_bit};
                halow_nxt   = 1'b0;
                hlvl_nxt    = 1'b0;
              end else begin
                offset_nxt = 17'd3;
              end
            end
          end else begin
            decided_nxt = 1'b1;
            hstat_nxt   = rdif_pkg::ST_FOUND;
            hgsi_nxt    = gsi_r;
            halow_nxt   = b[3];
            hlvl_nxt    = ~b[0];
          end
        end
        default: begin
          phase_nxt = rdif_pkg::PH_TAG;
        end
      endcase

      if (run_tag) begin
        tag_nxt    = b;
        offset_nxt = 17'd1;
        len_nxt    = 16'd0;
        if ((b & rdif_pkg::TAG_LARGE_BIT) != 8'd0) begin
          phase_nxt = rdif_pkg::PH_LARGE;
        end else if (b[6:3] == rdif_pkg::NAME_END) begin
          decided_nxt = 1'b1;
          hstat_nxt   = rdif_pkg::ST_END;
          hgsi_nxt    = 32'd0;
          halow_nxt   = 1'b0;
          hlvl_nxt    = 1'b0;
        end else if (b[6:3] == rdif_pkg::NAME_IRQ) begin
          len_nxt   = {13'd0, b[2:0]};
          phase_nxt = rdif_pkg::PH_IRQ;
        end else if (b[2:0] != 3'd0) begin
          len_nxt   = {13'd0, b[2:0]};
          phase_nxt = rdif_pkg::PH_SKIP;
        end else begin
          phase_nxt = rdif_pkg::PH_TAG;
        end
      end
    end

    result.found           = (hstat_nxt == rdif_pkg::ST_FOUND);
    result.gsi             = hgsi_nxt;
    result.pol_low         = halow_nxt;
    result.level_triggered = hlvl_nxt;
    result.status          = hstat_nxt;

    // Last byte: restart parsing for the next buffer
    if (step.last_byte) begin
      phase_nxt   = rdif_pkg::PH_TAG;
      offset_nxt  = 17'd0;
      tag_nxt     = 8'd0;
      len_nxt     = 16'd0;
      flags_nxt   = 8'd0;
      count_nxt   = 8'd0;
      gsi_nxt     = 32'd0;
      mask_lo_nxt = 8'd0;
      decided_nxt = 1'b0;
      hstat_nxt   = rdif_pkg::ST_OUT;
      hgsi_nxt    = 32'd0;
      halow_nxt   = 1'b0;
      hlvl_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rdif_pkg::PH_TAG;
      offset_r  <= 17'd0;
      tag_r     <= 8'd0;
      len_r     <= 16'd0;
      flags_r   <= 8'd0;
      count_r   <= 8'd0;
      gsi_r     <= 32'd0;
      mask_lo_r <= 8'd0;
      decided_r <= 1'b0;
      hstat_r   <= rdif_pkg::ST_OUT;
      hgsi_r    <= 32'd0;
      halow_r   <= 1'b0;
      hlvl_r    <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      offset_r  <= offset_nxt;
      tag_r     <= tag_nxt;
      len_r     <= len_nxt;
      flags_r   <= flags_nxt;
      count_r   <= count_nxt;
      gsi_r     <= gsi_nxt;
      mask_lo_r <= mask_lo_nxt;
      decided_r <= decided_nxt;
      hstat_r   <= hstat_nxt;
      hgsi_r    <= hgsi_nxt;
      halow_r   <= halow_nxt;
      hlvl_r    <= hlvl_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/resource_descriptor_irq_finder_unit.sv
// Path: a last byte accepted at the input waits in the input register; its result is then held in the output register.
// Throughput: one byte per cycle; the input register stalls only when a last byte
// finds the single output register still occupied.
// Reset: synchronous, active low; clears both valid flags and the parse state.
// Top level: input register, rdif_parser, output register. Depends on rdif_pkg.
`default_nettype none

module resource_descriptor_irq_finder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [rdif_pkg::OUT_DATA_W-1:0] out_tdata
  // out_tdata: [0] found, [32:1] gsi, [33] pol_low, [34] level_triggered,
  //            [36:35] status, [39:37] zero
);

  logic              in_valid_r;
  rdif_pkg::step_t   in_step_r;
  logic              advance;
  rdif_pkg::result_t result;
  logic              out_valid_r;
  rdif_pkg::result_t out_res_r;

  // Only a last byte needs room in the output register
  assign advance   = in_valid_r && (!in_step_r.last_byte || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_step_r.data_byte <= in_tdata;
      in_step_r.last_byte <= in_tlast;
    end
  end

  rdif_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .step    (in_step_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_step_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_step_r.last_byte) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r};

endmodule

`default_nettype wire

// File: design/rdif_checker.sv
// Port-level checks for the resource descriptor interrupt finder, bound to the top level.
// Depends on rdif_pkg.
`default_nettype none

module rdif_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [rdif_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[36:35] == rdif_pkg::ST_FOUND)))
    else $error("found flag disagrees with status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[34:1] == 34'd0)
    else $error("miss carries nonzero interrupt fields");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:37] == 3'd0)
    else $error("padding bits set");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind resource_descriptor_irq_finder_unit rdif_checker u_rdif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: bench/rdif_stream_checker.sv
// Stream checker for the resource descriptor interrupt finder: watches both
// channels, predicts each buffer's verdict from the accepted bytes, compares.
// Depends on rdif_pkg.
module rdif_stream_checker import rdif_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatch_count,
  output int                    verdicts_pending
);

  phase_t      phase;
  logic [16:0] offset;
  logic [7:0]  cur_tag;
  logic [15:0] desc_len;
  logic [7:0]  int_flags;
  logic [7:0]  int_count;
  logic [31:0] gsi_acc;
  logic [15:0] irq_mask;
  logic        decided;
  result_t     held_verdict;
  result_t     verdict_queue[$];
  int          errors_seen = 0;

  assign mismatch_count = errors_seen;

  task automatic restart_parse();
    phase        = PH_TAG;
    offset       = '0;
    cur_tag      = '0;
    desc_len     = '0;
    int_flags    = '0;
    int_count    = '0;
    gsi_acc      = '0;
    irq_mask     = '0;
    decided      = 1'b0;
    held_verdict = '0;
    held_verdict.status = ST_OUT;
  endtask

  task automatic conclude(input logic [1:0] st, input logic [31:0] g, input logic al,
                          input logic lv);
    held_verdict.found           = (st == ST_FOUND);
    held_verdict.gsi             = g;
    held_verdict.pol_low         = al;
    held_verdict.level_triggered = lv;
    held_verdict.status          = st;
    decided = 1'b1;
  endtask

  task automatic take_tag(input logic [7:0] b);
    cur_tag  = b;
    offset   = 17'd1;
    desc_len = '0;
    if (b[7]) begin
      phase = PH_LARGE;
    end else if (b[6:3] == NAME_END) begin
      conclude(ST_END, '0, 1'b0, 1'b0);
    end else if (b[6:3] == NAME_IRQ) begin
      desc_len = 16'(b[2:0]);
      phase    = PH_IRQ;
    end else if (b[2:0] != 3'd0) begin
      desc_len = 16'(b[2:0]);
      phase    = PH_SKIP;
    end else begin
      phase = PH_TAG;
    end
  endtask

  task automatic parse_template_byte(input logic [7:0] b, input logic lst);
    int unsigned k;
    int unsigned lsb;
    logic        is_ext;
    k = offset;
    case (phase)
      PH_TAG: take_tag(b);
      PH_LARGE: begin
        if (k == 1) desc_len = {8'h00, b};
        else if (k == 2) desc_len = desc_len | {b, 8'h00};
        is_ext = (cur_tag == TAG_EXT_IRQ) && (desc_len >= 16'd6);
        if (is_ext && k >= 3 && k <= 8) begin
          if (k == 3) begin
            int_flags = b;
          end else if (k == 4) begin
            int_count = b;
          end else begin
            gsi_acc = gsi_acc | (32'(b) << ((k - 5) * 8));
            if (k == 8 && int_count >= 8'd1) begin
              conclude(ST_FOUND, gsi_acc, int_flags[2], !int_flags[1]);
              return;
            end
          end
        end
        // descriptor done once the payload count is reached
        if (k >= 2 && k == 2 + desc_len) begin
          phase     = PH_TAG;
          offset    = '0;
          gsi_acc   = '0;
          int_flags = '0;
          int_count = '0;
        end else begin
          offset = 17'(k + 1);
        end
      end
      PH_SKIP: begin
        desc_len = desc_len - 16'd1;
        if (desc_len == 16'd0) phase = PH_TAG;
      end
      PH_IRQ: begin
        if (k == 1) begin
          // a zero-length IRQ tag followed by a lone last byte: treat it as a tag
          if (lst && desc_len == 16'd0) begin
            take_tag(b);
            return;
          end
          irq_mask = {8'h00, b};
          offset   = 17'd2;
        end else if (k == 2) begin
          irq_mask = irq_mask | {b, 8'h00};
          if (irq_mask == 16'd0) begin
            conclude(ST_EMPTY, '0, 1'b0, 1'b0);
            return;
          end
          lsb = 0;
          while (!irq_mask[lsb]) lsb++;
          gsi_acc = lsb;
          if (desc_len < 16'd3 || lst) conclude(ST_FOUND, gsi_acc, 1'b0, 1'b0);
          else offset = 17'd3;
        end else begin
          conclude(ST_FOUND, gsi_acc, b[3], !b[0]);
        end
      end
      default: phase = PH_TAG;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", fname, want_v, got_v);
      errors_seen++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      restart_parse();
      verdict_queue.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (!decided) parse_template_byte(in_tdata, in_tlast);
        if (in_tlast) begin
          verdict_queue.push_back(held_verdict);
          restart_parse();
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        if (verdict_queue.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          errors_seen++;
        end else begin
          want = verdict_queue.pop_front();
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("gsi", want.gsi, got.gsi);
          check_field("pol_low", 32'(want.pol_low), 32'(got.pol_low));
          check_field("level_triggered", 32'(want.level_triggered),
                      32'(got.level_triggered));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
    end
    verdicts_pending <= verdict_queue.size();
  end

endmodule

// File: bench/tb_resource_descriptor_irq_finder_unit.sv
// Top of the interrupt finder testbench: clock, reset, byte-stream stimulus,
// receiver backpressure, watchdog and verdict. Checking sits in rdif_stream_checker.
// Depends on rdif_pkg, rdif_stream_checker and resource_descriptor_irq_finder_unit.
module tb_resource_descriptor_irq_finder_unit;
  import rdif_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 550;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int         mismatch_count;
  int         verdicts_pending;
  logic [7:0] tmpl[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  bit         steady = 1'b0;
  int         hold_requests = 0;
  int         quiet_cycles = 0;

  resource_descriptor_irq_finder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rdif_stream_checker u_stream_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .verdicts_pending(verdicts_pending)
  );

  always #2 clk = ~clk;

  // send one buffer, last marked on its final byte; gaps come between bursts
  task automatic send_template();
    int gap;
    for (int i = 0; i < tmpl.size(); i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= tmpl[i];
      in_tlast  <= (i == tmpl.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
      if (!steady && burst_left == 0) begin
        burst_left = $urandom_range(12, 0);
        gap = $urandom_range(6, 1);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if (burst_left > 0) begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
  endtask

  // receiver: changing stall modes, plus a long hold when asked
  initial begin
    int holds_done;
    int rx_mode;
    int rx_tick;
    int rx_phase;
    holds_done = 0;
    rx_mode = 0;
    rx_tick = 0;
    rx_phase = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (rx_tick == 0) begin
          rx_mode = $urandom_range(3, 0);
          rx_tick = $urandom_range(80, 20);
        end else begin
          rx_tick--;
        end
        rx_phase = (rx_phase + 1) % 5;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(3, 0) != 0);
          2: out_tready <= ($urandom_range(3, 0) == 0);
          default: out_tready <= (rx_phase != 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("resource_descriptor_irq_finder_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          len;
    int          sh;
    int          cut;
    logic [3:0]  name;
    logic [7:0]  tag;
    logic [15:0] mask;
    logic [31:0] gsi_v;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // end tag alone
    tmpl = '{8'h78};
    send_template();
    // IRQ, only mask bit 15 set, no flags byte
    tmpl = '{8'h22, 8'h00, 8'h80};
    send_template();
    // IRQ with flags byte: active low, edge
    tmpl = '{8'h23, 8'h01, 8'h00, 8'h09};
    send_template();
    // IRQ with empty mask
    tmpl = '{8'h22, 8'h00, 8'h00};
    send_template();
    // extended interrupt, level, active low, all-ones GSI
    tmpl = '{8'h89, 8'h06, 8'h00, 8'h04, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_template();
    // zero-length IRQ tag cut short: lone last byte parses as an end tag
    tmpl = '{8'h20, 8'h78};
    send_template();
    // runs out right after an empty descriptor
    tmpl = '{8'h00};
    send_template();

    // long receiver hold while short buffers pile up against the output
    hold_requests <= hold_requests + 1;
    steady = 1'b1;
    repeat (8) begin
      tmpl = '{8'h78 | 8'($urandom_range(7, 0))};
      send_template();
    end
    steady = 1'b0;
    wait_drained();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      steady = ($urandom_range(4, 0) == 0);
      tmpl.delete();
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(12, 1)) tmpl.push_back(8'($urandom));
      end else begin
        // filler descriptors that get skipped
        repeat ($urandom_range(3, 0)) begin
          case ($urandom_range(2, 0))
            0: begin
              name = 4'($urandom_range(14, 0));
              if (name == NAME_IRQ) name = 4'h5;
              len = $urandom_range(7, 0);
              tmpl.push_back({1'b0, name, 3'(len)});
              repeat (len) tmpl.push_back(8'($urandom));
            end
            1: begin
              tag = 8'($urandom) | TAG_LARGE_BIT;
              if (tag == TAG_EXT_IRQ) tag = 8'h8A;
              len = $urandom_range(6, 0);
              tmpl.push_back(tag);
              tmpl.push_back(8'(len));
              tmpl.push_back(8'h00);
              repeat (len) tmpl.push_back(8'($urandom));
            end
            default: begin
              // extended interrupt that is too short or has no interrupts
              len = $urandom_range(8, 0);
              tmpl.push_back(TAG_EXT_IRQ);
              tmpl.push_back(8'(len));
              tmpl.push_back(8'h00);
              for (int j = 0; j < len; j++) tmpl.push_back(j == 1 ? 8'h00 : 8'($urandom));
            end
          endcase
        end
        case ($urandom_range(5, 0))
          0, 1: begin
            len = $urandom_range(4, 0);
            sh = $urandom_range(15, 0);
            mask = ($urandom_range(7, 0) == 0) ? 16'h0000
                 : ((16'($urandom) << sh) | (16'h0001 << sh));
            tmpl.push_back({1'b0, NAME_IRQ, 3'(len)});
            tmpl.push_back(mask[7:0]);
            tmpl.push_back(mask[15:8]);
            if (len >= 3) tmpl.push_back(8'($urandom));
          end
          2, 3: begin
            len = $urandom_range(9, 6);
            gsi_v = $urandom;
            tmpl.push_back(TAG_EXT_IRQ);
            tmpl.push_back(8'(len));
            tmpl.push_back(8'h00);
            tmpl.push_back(8'($urandom));
            tmpl.push_back(($urandom_range(5, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
            tmpl.push_back(gsi_v[7:0]);
            tmpl.push_back(gsi_v[15:8]);
            tmpl.push_back(gsi_v[23:16]);
            tmpl.push_back(gsi_v[31:24]);
            repeat (len - 6) tmpl.push_back(8'($urandom));
          end
          4: tmpl.push_back({1'b0, NAME_END, 3'($urandom_range(7, 0))});
          default: ;
        endcase
        // trailing bytes are ignored once a verdict is reached
        if (tmpl.size() == 0 || $urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(4, 1)) tmpl.push_back(8'($urandom));
        end
        if ($urandom_range(5, 0) == 0 && tmpl.size() > 1) begin
          cut = $urandom_range(tmpl.size() - 1, 1);
          tmpl = tmpl[0:cut-1];
        end
      end
      send_template();
      if ($urandom_range(29, 0) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("resource_descriptor_irq_finder_unit verification clean");
    end else begin
      $display("resource_descriptor_irq_finder_unit verification failed");
    end
    $finish;
  end

endmodule
